// ===== design/sgbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sgbs_pkg
// shared types and constants of the sorted group best select unit
// ----------------------------------------------------------------------------
package sgbs_pkg;

    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] site;
        logic [31:0] doc;
        logic [31:0] score;
        logic [63:0] popularity;
        logic [31:0] total;
        logic [31:0] mtime;
        logic [31:0] handle;
        logic [7:0]  section;
    } group_t;

    typedef struct packed {
        group_t grp;
        logic   fin;
    } result_t;

    typedef struct packed {
        logic push_first;
        logic push_second;
    } push_t;

endpackage

// ===== design/sgbs_merge.sv =====
// ----------------------------------------------------------------------------
// sgbs_merge
// folds one request into the open group and decides which groups close
// ----------------------------------------------------------------------------
module sgbs_merge
(
    input  logic                have_group,
    input  sgbs_pkg::group_t    cur_group,
    input  sgbs_pkg::group_t    rec,
    input  logic                last_item,
    output logic                have_group_next,
    output sgbs_pkg::group_t    group_next,
    output sgbs_pkg::push_t     push,
    output sgbs_pkg::result_t   first_result,
    output sgbs_pkg::result_t   second_result
);

    logic               same_site;
    logic               keep_old;
    logic [32:0]        sum;
    logic [31:0]        sat_total;
    sgbs_pkg::group_t   merged;
    sgbs_pkg::result_t  old_result;
    sgbs_pkg::result_t  fin_result;

    assign same_site = have_group && (cur_group.site == rec.site);
    assign sum       = {1'b0, cur_group.total} + {1'b0, rec.total};
    assign sat_total = sum[32] ? sgbs_pkg::COUNT_MAX : sum[31:0];

    always_comb
    begin
        if (cur_group.score != rec.score)
        begin
            keep_old = cur_group.score > rec.score;
        end
        else if (cur_group.popularity != rec.popularity)
        begin
            keep_old = cur_group.popularity > rec.popularity;
        end
        else
        begin
            keep_old = cur_group.doc < rec.doc;
        end
    end

    always_comb
    begin
        if (same_site)
        begin
            merged       = keep_old ? cur_group : rec;
            merged.site  = cur_group.site;
            merged.total = sat_total;
        end
        else
        begin
            merged = rec;
        end
    end

    assign group_next      = merged;
    assign have_group_next = !last_item;

    assign old_result = '{grp: cur_group, fin: 1'b0};
    assign fin_result = '{grp: merged, fin: 1'b1};

    // old group closes on a site change, the merged one on the last request
    assign push.push_first  = (have_group && !same_site) || last_item;
    assign push.push_second = have_group && !same_site && last_item;

    assign first_result  = (have_group && !same_site) ? old_result : fin_result;
    assign second_result = fin_result;

endmodule

// ===== design/sgbs_out_queue.sv =====
// ----------------------------------------------------------------------------
// sgbs_out_queue
// small result queue taking up to two results a cycle, one out a cycle while out_ready is high
// ----------------------------------------------------------------------------
module sgbs_out_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  sgbs_pkg::push_t     push,
    input  sgbs_pkg::result_t   first_result,
    input  sgbs_pkg::result_t   second_result,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output sgbs_pkg::result_t   head
);

    localparam int unsigned W = sgbs_pkg::QPTR_W;
    localparam int unsigned C = sgbs_pkg::QCNT_W;

    sgbs_pkg::result_t  entry_reg [sgbs_pkg::QDEPTH];
    logic [W-1:0]       wr_ptr_reg;
    logic [W-1:0]       wr_ptr_next;
    logic [W-1:0]       rd_ptr_reg;
    logic [W-1:0]       rd_ptr_next;
    logic [C-1:0]       count_reg;
    logic [C-1:0]       count_next;
    logic [W-1:0]       wr_ptr_second;
    logic               pop;
    logic [C-1:0]       n_push;

    assign pop           = out_valid && out_ready;
    assign n_push        = C'(push.push_first) + C'(push.push_second);
    assign wr_ptr_second = wr_ptr_reg + W'(1);
    assign wr_ptr_next   = wr_ptr_reg + W'(n_push);
    assign rd_ptr_next   = rd_ptr_reg + W'(pop);
    assign count_next    = count_reg + n_push - C'(pop);

    assign out_valid = count_reg != '0;
    assign has_room  = count_reg <= C'(sgbs_pkg::QDEPTH - 2);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    for (genvar i = 0; i < sgbs_pkg::QDEPTH; i++)
    begin : g_entry
        always_ff @(posedge clk)
        begin
            if (push.push_first && (wr_ptr_reg == W'(i)))
            begin
                entry_reg[i] <= first_result;
            end
            else if (push.push_second && (wr_ptr_second == W'(i)))
            begin
                entry_reg[i] <= second_result;
            end
        end
    end

endmodule

// ===== design/sorted_group_best_select_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_group_best_select_unit
// keeps the best record and a saturating count per run of equal site ids
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one document record per request,
//   sorted by site_key. output channel out_valid/out_ready carries finished
//   groups: site, best record, summed doc_count and final_group.
//   a group closes when site_key changes; a request with last_item set also
//   closes its own group with final_group high, so one request gives zero,
//   one or two results.
//   a closing request writes its results into the result queue when accepted.
//   throughput: one request per cycle while in_ready is high, set by the
//   single compare-and-merge step on the open group; both results of a request
//   go in at once; the four-entry queue drains one per cycle on out_ready.
//   in_ready is high while the result queue holds at most two results, so a
//   stalled receiver holds off the input once three results are pending.
//   reset empties the queue and closes any open group.
// ----------------------------------------------------------------------------
module sorted_group_best_select_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] site_key,
    input  logic [31:0] doc_id,
    input  logic [31:0] doc_score,
    input  logic [63:0] popularity,
    input  logic [31:0] doc_count,
    input  logic [31:0] modified_time,
    input  logic [31:0] text_handle,
    input  logic [7:0]  section_tag,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_site,
    output logic [31:0] out_doc,
    output logic [31:0] out_score,
    output logic [63:0] out_popularity,
    output logic [31:0] group_total,
    output logic [31:0] out_time,
    output logic [31:0] out_handle,
    output logic [7:0]  out_section,
    output logic        final_group
);

    logic               have_group_reg;
    logic               have_group_next;
    sgbs_pkg::group_t   group_reg;
    sgbs_pkg::group_t   group_next;
    sgbs_pkg::group_t   rec;
    sgbs_pkg::push_t    merge_push;
    sgbs_pkg::push_t    push;
    sgbs_pkg::result_t  first_result;
    sgbs_pkg::result_t  second_result;
    sgbs_pkg::result_t  head;
    logic               accept;

    assign accept = in_valid && in_ready;

    assign rec = '{site: site_key, doc: doc_id, score: doc_score,
                   popularity: popularity, total: doc_count,
                   mtime: modified_time, handle: text_handle,
                   section: section_tag};

    sgbs_merge u_merge
    (
        .have_group      (have_group_reg),
        .cur_group       (group_reg),
        .rec             (rec),
        .last_item       (last_item),
        .have_group_next (have_group_next),
        .group_next      (group_next),
        .push            (merge_push),
        .first_result    (first_result),
        .second_result   (second_result)
    );

    assign push.push_first  = accept && merge_push.push_first;
    assign push.push_second = accept && merge_push.push_second;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_group_reg <= 1'b0;
        end
        else if (accept)
        begin
            have_group_reg <= have_group_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            group_reg <= group_next;
        end
    end

    sgbs_out_queue u_queue
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .first_result  (first_result),
        .second_result (second_result),
        .has_room      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .head          (head)
    );

    assign out_site       = head.grp.site;
    assign out_doc        = head.grp.doc;
    assign out_score      = head.grp.score;
    assign out_popularity = head.grp.popularity;
    assign group_total    = head.grp.total;
    assign out_time       = head.grp.mtime;
    assign out_handle     = head.grp.handle;
    assign out_section    = head.grp.section;
    assign final_group    = head.fin;

endmodule
